[rtl/core/y86df_pkg.sv]
package y86df_pkg;

   localparam int unsigned WORD_WIDTH = 64;
   localparam int unsigned REG_WIDTH  = 4;
   localparam int unsigned REG_COUNT  = 15;

   localparam logic [REG_WIDTH-1:0] REG_NONE = 4'd15;
   localparam logic [REG_WIDTH-1:0] REG_RSP  = 4'd4;

   typedef enum logic [3:0] {
      IC_HALT   = 4'h0,
      IC_NOP    = 4'h1,
      IC_RRMOVQ = 4'h2,
      IC_IRMOVQ = 4'h3,
      IC_RMMOVQ = 4'h4,
      IC_MRMOVQ = 4'h5,
      IC_OPQ    = 4'h6,
      IC_JXX    = 4'h7,
      IC_CALL   = 4'h8,
      IC_RET    = 4'h9,
      IC_PUSHQ  = 4'hA,
      IC_POPQ   = 4'hB
   } icode_type;

   typedef enum logic {
      ACT_DECODE = 1'b0,
      ACT_WRITE  = 1'b1
   } action_type;

   typedef struct packed {
      logic                  action;
      logic [1:0]            status;
      logic [7:0]            opcode_byte;
      logic [REG_WIDTH-1:0]  reg_a;
      logic [REG_WIDTH-1:0]  reg_b;
      logic [WORD_WIDTH-1:0] constant_word;
      logic [REG_WIDTH-1:0]  exec_dest;
      logic [WORD_WIDTH-1:0] exec_value;
      logic [REG_WIDTH-1:0]  mem_dest;
      logic [WORD_WIDTH-1:0] mem_value;
      logic [REG_WIDTH-1:0]  wb_dest;
      logic [WORD_WIDTH-1:0] wb_value;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]            out_status;
      logic [7:0]            out_opcode;
      logic [WORD_WIDTH-1:0] out_constant;
      logic [WORD_WIDTH-1:0] operand_a;
      logic [WORD_WIDTH-1:0] operand_b;
      logic [REG_WIDTH-1:0]  dest_e;
      logic [REG_WIDTH-1:0]  dest_m;
      logic [REG_WIDTH-1:0]  source_a;
      logic [REG_WIDTH-1:0]  source_b;
   } rsp_payload_type;

   typedef struct packed {
      logic [REG_WIDTH-1:0] src_a;
      logic [REG_WIDTH-1:0] src_b;
      logic [REG_WIDTH-1:0] dst_e;
      logic [REG_WIDTH-1:0] dst_m;
   } sel_type;

   function automatic sel_type decode_sel(logic [3:0] icode, logic [REG_WIDTH-1:0] ra,
                                          logic [REG_WIDTH-1:0] rb);
      sel_type sel;
      sel = '{src_a: REG_NONE, src_b: REG_NONE, dst_e: REG_NONE, dst_m: REG_NONE};
      case (icode)
         IC_RRMOVQ: begin
            sel.src_a = ra;
            sel.dst_e = rb;
         end
         IC_IRMOVQ: begin
            sel.dst_e = rb;
         end
         IC_RMMOVQ: begin
            sel.src_a = ra;
            sel.src_b = rb;
         end
         IC_MRMOVQ: begin
            sel.src_b = rb;
            sel.dst_m = ra;
         end
         IC_OPQ: begin
            sel.src_a = ra;
            sel.src_b = rb;
            sel.dst_e = rb;
         end
         IC_CALL: begin
            sel.src_b = REG_RSP;
            sel.dst_e = REG_RSP;
         end
         IC_RET: begin
            sel.src_a = REG_RSP;
            sel.src_b = REG_RSP;
            sel.dst_e = REG_RSP;
         end
         IC_PUSHQ: begin
            sel.src_a = ra;
            sel.src_b = REG_RSP;
            sel.dst_e = REG_RSP;
         end
         IC_POPQ: begin
            sel.src_a = REG_RSP;
            sel.src_b = REG_RSP;
            sel.dst_e = REG_RSP;
            sel.dst_m = ra;
         end
         default: begin
            sel = '{src_a: REG_NONE, src_b: REG_NONE, dst_e: REG_NONE, dst_m: REG_NONE};
         end
      endcase
      return sel;
   endfunction

   // execute beats memory beats writeback beats the register file
   function automatic logic [WORD_WIDTH-1:0] pick_operand(logic [REG_WIDTH-1:0] src,
                                                          req_payload_type item,
                                                          logic [WORD_WIDTH-1:0] rf_data,
                                                          logic rf_valid);
      logic [WORD_WIDTH-1:0] val;
      if (src == REG_NONE) begin
         val = '0;
      end else if (src == item.exec_dest) begin
         val = item.exec_value;
      end else if (src == item.mem_dest) begin
         val = item.mem_value;
      end else if (src == item.wb_dest) begin
         val = item.wb_value;
      end else if (rf_valid) begin
         val = rf_data;
      end else begin
         val = '0;
      end
      return val;
   endfunction

endpackage

[rtl/core/y86df_chan_if.sv]
interface y86df_chan_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

[rtl/core/y86_decode_forwarding_core.sv]
// Decode stage of a Y86-64 pipeline with operand forwarding. Each request word either
// decodes one instruction (one response word: srcA/srcB/dstE/dstM chosen by icode and
// valA/valB forwarded from execute, then memory, then writeback, else the register file)
// or writes one register file entry (no response). One word is taken every clock
// while the response side is not stalled. A decode is held in the decode stage register
// while the registered read of the register file RAM completes, and is then loaded into
// the response register after the forwarding mux, where the sink takes it; a stalled
// response holds the decode stage and the request side. The fifteen registers read as
// zero after reset until written; there is no clearing pass.
module y86_decode_forwarding_core
   import y86df_pkg::*;
(
   input logic          clock,
   input logic          reset,
   y86df_chan_if.sink   req_ch,
   y86df_chan_if.source rsp_ch
);

   localparam int unsigned RF_AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

   req_payload_type req_word;
   sel_type         sel_in;

   logic            out_free;
   logic            s1_move;
   logic            req_ready;
   logic            req_fire;
   logic            dec_fire;
   logic            wr_fire;

   logic [RF_AW-1:0] rd_addr_a;
   logic [RF_AW-1:0] rd_addr_b;
   logic [RF_AW-1:0] wr_addr;
   logic [WORD_WIDTH-1:0] rf_data_a;
   logic [WORD_WIDTH-1:0] rf_data_b;

   logic [REG_COUNT-1:0] valid_ff, valid_in;

   logic            s1_valid_ff, s1_valid_in;
   req_payload_type s1_req_ff;
   sel_type         s1_sel_ff;
   logic            s1_vld_a_ff, s1_vld_b_ff;

   logic            out_valid_ff, out_valid_in;
   rsp_payload_type out_ff, out_in;

   assign req_word = req_ch.data;
   assign sel_in   = decode_sel(req_word.opcode_byte[7:4], req_word.reg_a, req_word.reg_b);

   // handshake and stage advance
   assign out_free  = !out_valid_ff || rsp_ch.ready;
   assign s1_move   = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || out_free;
   assign req_fire  = req_ch.valid && req_ready;
   assign dec_fire  = req_fire && (req_word.action == ACT_DECODE);
   assign wr_fire   = req_fire && (req_word.action == ACT_WRITE) &&
                      (req_word.wb_dest != REG_NONE);

   assign req_ch.ready = req_ready;
   assign rsp_ch.valid = out_valid_ff;
   assign rsp_ch.data  = out_ff;

   // no-source reads are masked later, so park them on entry zero
   assign rd_addr_a = (sel_in.src_a == REG_NONE) ? '0 : sel_in.src_a[RF_AW-1:0];
   assign rd_addr_b = (sel_in.src_b == REG_NONE) ? '0 : sel_in.src_b[RF_AW-1:0];
   assign wr_addr   = req_word.wb_dest[RF_AW-1:0];

   y86df_ram #(
      .WIDTH (WORD_WIDTH),
      .DEPTH (REG_COUNT)
   ) u_regfile (
      .clock     (clock),
      .wr_en     (wr_fire),
      .wr_addr   (wr_addr),
      .wr_data   (req_word.wb_value),
      .rd_en     (dec_fire),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rf_data_a),
      .rd_data_b (rf_data_b)
   );

   always_comb begin
      valid_in = valid_ff;
      if (wr_fire) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_comb begin
      if (dec_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_comb begin
      if (s1_move) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_comb begin
      out_in.out_status   = s1_req_ff.status;
      out_in.out_opcode   = s1_req_ff.opcode_byte;
      out_in.out_constant = s1_req_ff.constant_word;
      out_in.operand_a    = pick_operand(s1_sel_ff.src_a, s1_req_ff, rf_data_a, s1_vld_a_ff);
      out_in.operand_b    = pick_operand(s1_sel_ff.src_b, s1_req_ff, rf_data_b, s1_vld_b_ff);
      out_in.dest_e       = s1_sel_ff.dst_e;
      out_in.dest_m       = s1_sel_ff.dst_m;
      out_in.source_a     = s1_sel_ff.src_a;
      out_in.source_b     = s1_sel_ff.src_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (dec_fire) begin
         s1_req_ff   <= req_word;
         s1_sel_ff   <= sel_in;
         s1_vld_a_ff <= valid_ff[rd_addr_a];
         s1_vld_b_ff <= valid_ff[rd_addr_b];
      end
      if (s1_move) begin
         out_ff <= out_in;
      end
   end

   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> (valid_ff == '0) && !s1_valid_ff && !out_valid_ff)
      else $error("state not cleared by reset");

   a_none_a_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (out_ff.source_a == REG_NONE)) |-> (out_ff.operand_a == '0))
      else $error("operand a nonzero with no source");

   a_none_b_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (out_ff.source_b == REG_NONE)) |-> (out_ff.operand_b == '0))
      else $error("operand b nonzero with no source");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_free) |=> s1_valid_ff && $stable(s1_req_ff) && $stable(s1_sel_ff))
      else $error("decode stage lost its word while blocked");

   a_write_no_stage: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_word.action == ACT_WRITE) && !s1_valid_ff) |=> !s1_valid_ff)
      else $error("register write entered the decode stage");

endmodule

[rtl/core/y86df_ram.sv]
module y86df_ram #(
   parameter int unsigned WIDTH = 64,
   parameter int unsigned DEPTH = 15
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr_a,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]                         rd_data_a,
   output logic [WIDTH-1:0]                         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule
